// ----- src/cct_pkg.sv -----
package cct_pkg;

    // command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_YEAR_LOW      = 2'd0;
    localparam logic [1:0] CFG_YEAR_HIGH     = 2'd1;
    localparam logic [1:0] CFG_YEAR_FALLBACK = 2'd2;

    localparam logic [11:0] YEAR_LOW_RST      = 12'd1920;
    localparam logic [11:0] YEAR_HIGH_RST     = 12'd2019;
    localparam logic [11:0] YEAR_FALLBACK_RST = 12'd2011;

    localparam logic [5:0] SEC_MAX   = 6'd59;
    localparam logic [5:0] MIN_MAX   = 6'd59;
    localparam logic [4:0] HOUR_MAX  = 5'd23;
    localparam logic [3:0] MONTH_MAX = 4'd12;
    localparam logic [3:0] MONTH_FEB = 4'd2;

    typedef struct packed {
        logic        command;
        logic [3:0]  load_month;
        logic [4:0]  load_day;
        logic [11:0] load_year;
        logic [4:0]  load_hour;
        logic [5:0]  load_minute;
        logic [5:0]  load_second;
    } t_cmd_beat;

    typedef struct packed {
        logic [5:0]  cur_second;
        logic [5:0]  cur_minute;
        logic [4:0]  cur_hour;
        logic [4:0]  cur_day;
        logic [3:0]  cur_month;
        logic [11:0] cur_year;
        logic        corrected;
    } t_res_beat;

    // calendar state
    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } t_cal;

    // year window registers
    typedef struct packed {
        logic [11:0] low;
        logic [11:0] high;
        logic [11:0] fallback;
    } t_year_win;

    // 4/100/400 rule without a divider: with z = y/4, z is a multiple of 25
    // exactly when z*41 mod 1024 lands in 0..40 (41 is the inverse of 25).
    function automatic logic is_leap(input logic [11:0] y);
        logic [9:0] z;
        logic [9:0] p;
        logic       div25;
        z     = y[11:2];
        p     = 10'(z * 10'd41);
        div25 = (p <= 10'd40);
        return (y[1:0] == 2'b00) && (!div25 || (z[1:0] == 2'b00));
    endfunction

    // days in month, 0 for a month code outside 1..12
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:                                       d = leap ? 5'd29 : 5'd28;
            default:                                    d = 5'd0;
        endcase
        return d;
    endfunction

    function automatic logic day_ok(input logic [5:0] d, input logic [3:0] m,
                                    input logic [11:0] y);
        logic [4:0] lim;
        lim = month_days(m, is_leap(y));
        return (d != 6'd0) && (d <= {1'b0, lim});
    endfunction

    function automatic logic year_in_win(input logic [12:0] y, input t_year_win w);
        return (y >= {1'b0, w.low}) && (y <= {1'b0, w.high});
    endfunction

endpackage

// ----- src/cct_stream_if.sv -----
interface cct_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/calendar_clock_tick.sv -----
// Channel   Dir  Payload           Notes
// i_cmd     in   cct_pkg::t_cmd_beat  tick (command 0) or load (command 1)
// o_res     out  cct_pkg::t_res_beat  calendar after the beat, corrected flag
// i_cfg_*   in   2-bit index, 12 bits year_low / year_high / year_fallback
//
// One beat per cycle sustained while o_res.ready is high; a beat passes the input
// register, then the date logic into the result register, which drives o_res.valid.
// The calendar registers update when a beat leaves the input register.
// Stalls: o_res.ready low holds the result; the input register still takes one
// more beat, then i_cmd.ready drops until the result drains.
// Reset (sync, active low): 00:00:00, January 1, 2011; window 1920..2019, fallback 2011.
module calendar_clock_tick (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cct_stream_if.sink           i_cmd,
    cct_stream_if.source         o_res,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [11:0]          i_cfg_data
);

    // input stage
    logic               r_in_vld;
    cct_pkg::t_cmd_beat r_in;
    // result stage
    logic               r_out_vld;
    cct_pkg::t_res_beat r_out;
    // calendar and window
    cct_pkg::t_cal      r_cal;
    cct_pkg::t_year_win r_win;

    cct_pkg::t_cal      n_cal;
    logic               n_corr;
    logic               w_adv;
    logic               w_take;

    // input beat moves to the result stage when that stage is free or draining
    assign w_adv  = r_in_vld && (!r_out_vld || o_res.ready);
    assign w_take = i_cmd.valid && i_cmd.ready;

    assign i_cmd.ready   = !r_in_vld || w_adv;
    assign o_res.valid   = r_out_vld;
    assign o_res.payload = r_out;

    cct_date_calc u_calc (
        .i_cmd  (r_in),
        .i_cal  (r_cal),
        .i_win  (r_win),
        .o_cal  (n_cal),
        .o_corr (n_corr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld       <= 1'b0;
            r_out_vld      <= 1'b0;
            r_cal.second   <= 6'd0;
            r_cal.minute   <= 6'd0;
            r_cal.hour     <= 5'd0;
            r_cal.day      <= 5'd1;
            r_cal.month    <= 4'd1;
            r_cal.year     <= cct_pkg::YEAR_FALLBACK_RST;
            r_win.low      <= cct_pkg::YEAR_LOW_RST;
            r_win.high     <= cct_pkg::YEAR_HIGH_RST;
            r_win.fallback <= cct_pkg::YEAR_FALLBACK_RST;
        end else begin
            if (w_take) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end

            if (w_adv) begin
                r_out_vld <= 1'b1;
                r_cal     <= n_cal;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end

            // the user must let config arrive only while idle; the block does not enforce it; unknown index is dropped
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cct_pkg::CFG_YEAR_LOW:      r_win.low      <= i_cfg_data;
                    cct_pkg::CFG_YEAR_HIGH:     r_win.high     <= i_cfg_data;
                    cct_pkg::CFG_YEAR_FALLBACK: r_win.fallback <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= i_cmd.payload;
        end
        if (w_adv) begin
            r_out.cur_second <= n_cal.second;
            r_out.cur_minute <= n_cal.minute;
            r_out.cur_hour   <= n_cal.hour;
            r_out.cur_day    <= n_cal.day;
            r_out.cur_month  <= n_cal.month;
            r_out.cur_year   <= n_cal.year;
            r_out.corrected  <= n_corr;
        end
    end

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cal.month >= 4'd1 && r_cal.month <= cct_pkg::MONTH_MAX)
        else $error("month out of range");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cal.second <= cct_pkg::SEC_MAX && r_cal.minute <= cct_pkg::MIN_MAX &&
        r_cal.hour <= cct_pkg::HOUR_MAX)
        else $error("time of day out of range");

    a_day_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cal.day != 5'd0)
        else $error("day is zero");

    // a tick only corrects on a year rollover, i.e. at midnight, January 1
    a_tick_corr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_in.command == cct_pkg::CMD_TICK && n_corr |->
        n_cal.month == 4'd1 && n_cal.day == 5'd1 && n_cal.hour == 5'd0)
        else $error("tick corrected outside year rollover");

    a_res_matches_cal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_vld && r_out.cur_year == r_cal.year &&
        r_out.cur_day == r_cal.day && r_out.cur_second == r_cal.second)
        else $error("result beat differs from calendar state");

endmodule

// ----- src/cct_date_calc.sv -----
// Next calendar state for one beat: tick carry chain or checked load.
module cct_date_calc (
    input  cct_pkg::t_cmd_beat i_cmd,
    input  cct_pkg::t_cal      i_cal,
    input  cct_pkg::t_year_win i_win,
    output cct_pkg::t_cal      o_cal,
    output logic               o_corr
);

    logic [5:0]  w_day_inc;
    logic [12:0] w_year_inc;
    logic [12:0] w_load_year;

    assign w_day_inc   = {1'b0, i_cal.day} + 6'd1;
    assign w_year_inc  = {1'b0, i_cal.year} + 13'd1;
    assign w_load_year = {1'b0, i_cmd.load_year};

    always_comb begin
        o_cal  = i_cal;
        o_corr = 1'b0;
        if (i_cmd.command == cct_pkg::CMD_LOAD) begin
            // month first, then year, then day against both
            if (i_cmd.load_month >= 4'd1 && i_cmd.load_month <= cct_pkg::MONTH_MAX) begin
                o_cal.month = i_cmd.load_month;
            end else begin
                o_cal.month = 4'd1;
                o_corr      = 1'b1;
            end
            if (cct_pkg::year_in_win(w_load_year, i_win)) begin
                o_cal.year = i_cmd.load_year;
            end else begin
                o_cal.year = i_win.fallback;
                o_corr     = 1'b1;
            end
            if (cct_pkg::day_ok({1'b0, i_cmd.load_day}, o_cal.month, o_cal.year)) begin
                o_cal.day = i_cmd.load_day;
            end else begin
                o_cal.day = 5'd1;
                o_corr    = 1'b1;
            end
            if (i_cmd.load_hour <= cct_pkg::HOUR_MAX) begin
                o_cal.hour = i_cmd.load_hour;
            end else begin
                o_cal.hour = 5'd0;
                o_corr     = 1'b1;
            end
            if (i_cmd.load_minute <= cct_pkg::MIN_MAX) begin
                o_cal.minute = i_cmd.load_minute;
            end else begin
                o_cal.minute = 6'd0;
                o_corr       = 1'b1;
            end
            if (i_cmd.load_second <= cct_pkg::SEC_MAX) begin
                o_cal.second = i_cmd.load_second;
            end else begin
                o_cal.second = 6'd0;
                o_corr       = 1'b1;
            end
        end else begin
            if (i_cal.second < cct_pkg::SEC_MAX) begin
                o_cal.second = i_cal.second + 6'd1;
            end else begin
                o_cal.second = 6'd0;
                if (i_cal.minute < cct_pkg::MIN_MAX) begin
                    o_cal.minute = i_cal.minute + 6'd1;
                end else begin
                    o_cal.minute = 6'd0;
                    if (i_cal.hour < cct_pkg::HOUR_MAX) begin
                        o_cal.hour = i_cal.hour + 5'd1;
                    end else begin
                        o_cal.hour = 5'd0;
                        if (cct_pkg::day_ok(w_day_inc, i_cal.month, i_cal.year)) begin
                            o_cal.day = w_day_inc[4:0];
                        end else begin
                            o_cal.day = 5'd1;
                            if (i_cal.month < cct_pkg::MONTH_MAX) begin
                                o_cal.month = i_cal.month + 4'd1;
                            end else begin
                                o_cal.month = 4'd1;
                                // 4095 rolls to 4096, always out of window
                                if (cct_pkg::year_in_win(w_year_inc, i_win)) begin
                                    o_cal.year = w_year_inc[11:0];
                                end else begin
                                    o_cal.year = i_win.fallback;
                                    o_corr     = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
        end
    end

endmodule
